// ===== sv/krat_pkg.sv =====
// Shared types and constants for the keyed running average table.
package krat_pkg;

  localparam logic [1:0] STATUS_UPDATED  = 2'd0;
  localparam logic [1:0] STATUS_CREATED  = 2'd1;
  localparam logic [1:0] STATUS_REJECTED = 2'd2;

  localparam logic CFG_LOW_LIMIT  = 1'b0;
  localparam logic CFG_HIGH_LIMIT = 1'b1;

  // Per-cell match report toward the controller.
  typedef struct packed {
    logic hit;
  } cell_stat_t;

endpackage

// ===== sv/krat_cell.sv =====
// One table slot: identifier, sample count and sample window as a shift line.
module krat_cell #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    alloc_i,
  input  logic                    ins_i,
  input  logic                    rot_i,
  input  logic [15:0]             key_i,
  input  logic [15:0]             rd_i,
  input  logic                    used_i,
  output krat_pkg::cell_stat_t    stat_o,
  output logic [$clog2(WINDOW+1)-1:0] cnt_o,
  output logic [15:0]             head_o
);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned WW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [15:0]   id_q;
  logic [CW-1:0] cnt_q;
  logic [15:0]   win_q [WINDOW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q  <= '0;
      cnt_q <= '0;
    end else if (alloc_i) begin
      id_q  <= key_i;
      cnt_q <= CW'(1);
    end else if (ins_i && (cnt_q < CW'(WINDOW))) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // win_q[0] is the oldest; rotation brings each sample to the head once.
  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      for (int k = 0; k < WINDOW; k++) win_q[k] <= rd_i;
    end else if (ins_i) begin
      if (cnt_q < CW'(WINDOW)) begin
        win_q[cnt_q[WW-1:0]] <= rd_i;
      end else begin
        for (int k = 0; k < WINDOW - 1; k++) win_q[k] <= win_q[k+1];
        win_q[WINDOW-1] <= rd_i;
      end
    end else if (rot_i) begin
      for (int k = 0; k < WINDOW - 1; k++) win_q[k] <= win_q[k+1];
      win_q[WINDOW-1] <= win_q[0];
    end
  end

  assign stat_o.hit = used_i && (id_q == key_i);
  assign cnt_o      = cnt_q;
  assign head_o     = win_q[0];
endmodule

// ===== sv/keyed_running_average_table.sv =====
// Top level of the keyed running average table.
// One reading is taken per transaction on start_i while busy_o is low. The
// controller scans the slots one per cycle; a reading from an unknown sensor
// on a full table is rejected there. Otherwise it rotates the matching slot's
// window through a single accumulator, one sample per cycle, then runs a
// bit-serial signed division (a step to take the magnitude, then a step per
// bit of the 21-bit sum). The receiver
// cannot stall, so the result appears on done_o for one cycle.
module keyed_running_average_table #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned WINDOW      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] sensor_id_i,
  input  logic [15:0] reading_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  entry_index_o,
  output logic [15:0] average_o,
  output logic [3:0]  sample_count_o,
  output logic        too_cold_o,
  output logic        too_hot_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned UW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned SW = 16 + $clog2(WINDOW + 1) + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]    state_q;
  logic [UW-1:0] used_q;
  logic [IW-1:0] idx_q;
  logic [15:0]   key_q, rd_q;
  logic [1:0]    status_q;
  logic signed [15:0] low_q, high_q;
  logic signed [SW-1:0] sum_q;
  logic [CW-1:0] n_q, k_q;
  logic [SW-1:0] mag_q, quo_q, rem_q;
  logic [5:0]    bit_q;
  logic          neg_q;

  krat_pkg::cell_stat_t stat [MAX_ENTRIES];
  logic [CW-1:0] cnt  [MAX_ENTRIES];
  logic [15:0]   head [MAX_ENTRIES];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    krat_cell #(.WINDOW(WINDOW)) u_cell (
      .clk_i, .rst_ni,
      .alloc_i(state_q == ST_UPD && status_q == krat_pkg::STATUS_CREATED
               && idx_q == IW'(g)),
      .ins_i  (state_q == ST_UPD && status_q == krat_pkg::STATUS_UPDATED
               && idx_q == IW'(g)),
      .rot_i  (state_q == ST_SUM && idx_q == IW'(g)),
      .key_i  (key_q), .rd_i(rd_q),
      .used_i (UW'(g) < used_q),
      .stat_o (stat[g]), .cnt_o(cnt[g]), .head_o(head[g])
    );
  end

  assign busy_o      = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;

  // Restoring divider: magnitude bits enter the remainder MSB first.
  logic [SW-1:0] rem_sh;
  assign rem_sh = {rem_q[SW-2:0], mag_q[SW-1]};
  logic signed [15:0] avg;
  assign avg = neg_q ? -$signed(quo_q[15:0]) : $signed(quo_q[15:0]);
  logic full;
  assign full = n_q >= CW'(WINDOW);

  // table full and the last used slot missed
  logic rej;
  assign rej = (state_q == ST_SCAN) && !stat[idx_q].hit
               && (32'(idx_q) + 1 >= 32'(used_q)) && (used_q >= UW'(MAX_ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      used_q         <= '0;
      idx_q          <= '0;
      key_q          <= '0;
      rd_q           <= '0;
      status_q       <= krat_pkg::STATUS_UPDATED;
      low_q          <= -16'sd32768;
      high_q         <= 16'sd32767;
      sum_q          <= '0;
      n_q            <= '0;
      k_q            <= '0;
      mag_q          <= '0;
      quo_q          <= '0;
      rem_q          <= '0;
      bit_q          <= '0;
      neg_q          <= 1'b0;
      done_o         <= 1'b0;
      status_o       <= krat_pkg::STATUS_UPDATED;
      entry_index_o  <= '0;
      average_o      <= '0;
      sample_count_o <= '0;
      too_cold_o     <= 1'b0;
      too_hot_o      <= 1'b0;
    end else begin
      done_o <= (state_q == ST_OUT) || rej;
      if (cfg_valid_i) begin
        if (cfg_index_i == krat_pkg::CFG_LOW_LIMIT) low_q <= cfg_data_i;
        else high_q <= cfg_data_i;
      end
      case (state_q)
        ST_IDLE: if (start_i) begin
          key_q <= sensor_id_i; rd_q <= reading_i; idx_q <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (stat[idx_q].hit) begin
            status_q <= krat_pkg::STATUS_UPDATED; state_q <= ST_UPD;
          end else if (32'(idx_q) + 1 >= 32'(used_q)) begin
            if (used_q >= UW'(MAX_ENTRIES)) begin
              status_q <= krat_pkg::STATUS_REJECTED;
              status_o <= krat_pkg::STATUS_REJECTED;
              entry_index_o <= '0; average_o <= '0; sample_count_o <= '0;
              too_cold_o <= 1'b0; too_hot_o <= 1'b0; state_q <= ST_IDLE;
            end else begin
              status_q <= krat_pkg::STATUS_CREATED;
              idx_q <= used_q[IW-1:0]; used_q <= used_q + UW'(1);
              state_q <= ST_UPD;
            end
          end else idx_q <= idx_q + IW'(1);
        end
        ST_UPD: begin
          sum_q <= '0; k_q <= '0; state_q <= ST_SUM;
          n_q <= cnt[idx_q];
        end
        ST_SUM: begin
          n_q <= cnt[idx_q];
          if (k_q < cnt[idx_q])
            sum_q <= sum_q + SW'($signed(head[idx_q]));
          k_q <= k_q + CW'(1);
          if (k_q == CW'(WINDOW - 1)) begin
            state_q <= ST_DIV;
            bit_q <= '0; rem_q <= '0; quo_q <= '0;
          end
        end
        ST_DIV: begin
          if (bit_q == 6'd0) begin
            neg_q <= sum_q[SW-1];
            mag_q <= sum_q[SW-1] ? -sum_q : sum_q;
            bit_q <= 6'd1;
          end else begin
            mag_q <= {mag_q[SW-2:0], 1'b0};
            if (rem_sh >= SW'(n_q)) begin
              rem_q <= rem_sh - SW'(n_q); quo_q <= {quo_q[SW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh; quo_q <= {quo_q[SW-2:0], 1'b0};
            end
            if (bit_q == 6'(SW)) state_q <= ST_OUT;
            else bit_q <= bit_q + 6'd1;
          end
        end
        ST_OUT: begin
          status_o <= status_q;
          entry_index_o <= 4'(idx_q); average_o <= avg;
          sample_count_o <= 4'(n_q);
          too_cold_o <= full && (avg < low_q);
          too_hot_o  <= full && (avg > high_q);
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(MAX_ENTRIES)) else $error("slot count overflow");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held two cycles");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |=> done_o && !busy_o) else $error("missing result");
endmodule

// ===== dv/krat_checker.sv =====
// Checker for the keyed running average table: predicts each reading's result and compares.
module krat_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [15:0] sensor_id_i,
  input  logic [15:0] reading_i,
  input  logic        done_o,
  input  logic [1:0]  status_o,
  input  logic [3:0]  entry_index_o,
  input  logic [15:0] average_o,
  input  logic [3:0]  sample_count_o,
  input  logic        too_cold_o,
  input  logic        too_hot_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int SLOTS = 16;
  localparam int DEPTH = 8;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  entry_index;
    logic [15:0] average;
    logic [3:0]  sample_count;
    logic        too_cold;
    logic        too_hot;
  } avg_result_t;

  int                 slots_used;
  logic [15:0]        slot_id [SLOTS];
  int                 slot_fill [SLOTS];
  logic signed [15:0] slot_win [SLOTS][DEPTH];
  logic signed [15:0] low_lim;
  logic signed [15:0] high_lim;
  avg_result_t        expected_results [$];

  initial fail_count_o = 0;
  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  // Updates the table for one reading and returns its result.
  function automatic avg_result_t predict_reading(input logic [15:0] id,
                                                  input logic signed [15:0] rd);
    avg_result_t r;
    int          slot;
    int          sum;
    int          avg;
    bit          hit;
    r = '0;
    slot = 0;
    hit = 0;
    for (int i = 0; i < slots_used; i++) begin
      if (!hit && slot_id[i] == id) begin
        slot = i;
        hit = 1;
      end
    end
    if (hit) begin
      if (slot_fill[slot] < DEPTH) begin
        slot_win[slot][slot_fill[slot]] = rd;
        slot_fill[slot]++;
      end else begin
        for (int k = 0; k < DEPTH - 1; k++) slot_win[slot][k] = slot_win[slot][k+1];
        slot_win[slot][DEPTH-1] = rd;
      end
      r.status = krat_pkg::STATUS_UPDATED;
    end else if (slots_used >= SLOTS) begin
      r.status = krat_pkg::STATUS_REJECTED;
      return r;
    end else begin
      slot = slots_used;
      slot_id[slot] = id;
      slot_fill[slot] = 1;
      slot_win[slot][0] = rd;
      slots_used++;
      r.status = krat_pkg::STATUS_CREATED;
    end
    sum = 0;
    for (int k = 0; k < slot_fill[slot]; k++) sum += int'(slot_win[slot][k]);
    avg = sum / slot_fill[slot];
    r.entry_index  = slot[3:0];
    r.average      = avg[15:0];
    r.sample_count = slot_fill[slot][3:0];
    r.too_cold     = (slot_fill[slot] >= DEPTH) && (avg < int'(low_lim));
    r.too_hot      = (slot_fill[slot] >= DEPTH) && (avg > int'(high_lim));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    avg_result_t e;
    if (!rst_ni) begin
      slots_used = 0;
      low_lim  = 16'sh8000;
      high_lim = 16'sh7fff;
      expected_results.delete();
    end else begin
      // result first: it may share an edge with the next accepted reading
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_results.pop_front();
          if (status_o !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, e.status));
          if (entry_index_o !== e.entry_index)
            report_mismatch($sformatf("entry_index %0d, want %0d",
                                      entry_index_o, e.entry_index));
          if (average_o !== e.average)
            report_mismatch($sformatf("average %h, want %h", average_o, e.average));
          if (sample_count_o !== e.sample_count)
            report_mismatch($sformatf("sample_count %0d, want %0d",
                                      sample_count_o, e.sample_count));
          if (too_cold_o !== e.too_cold)
            report_mismatch($sformatf("too_cold %b, want %b", too_cold_o, e.too_cold));
          if (too_hot_o !== e.too_hot)
            report_mismatch($sformatf("too_hot %b, want %b", too_hot_o, e.too_hot));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == krat_pkg::CFG_LOW_LIMIT) low_lim = cfg_data_i;
        else high_lim = cfg_data_i;
      end
      if (start_i && !busy_o)
        expected_results.push_back(predict_reading(sensor_id_i, reading_i));
    end
  end

endmodule

// ===== dv/tb_keyed_running_average_table.sv =====
// Testbench top: stimulus and verdict for the keyed running average table.
module tb_keyed_running_average_table;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [15:0] sensor_id_i = '0;
  logic [15:0] reading_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [3:0]  entry_index_o;
  logic [15:0] average_o;
  logic [3:0]  sample_count_o;
  logic        too_cold_o;
  logic        too_hot_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = krat_pkg::CFG_LOW_LIMIT;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;

  // Sensor ids that own a table slot; fresh ids beyond these get rejected.
  logic [15:0] known_ids [16];
  int          idle_pct;

  always #2 clk_i = ~clk_i;

  keyed_running_average_table dut (.*);

  krat_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .sensor_id_i, .reading_i,
    .done_o, .status_o, .entry_index_o, .average_o, .sample_count_o,
    .too_cold_o, .too_hot_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // Run limit: far beyond the ~1300 readings plus their idle gaps.
  initial begin
    #2000000;
    $display("tb_keyed_running_average_table NOT OK");
    $finish;
  end

  // One reading transaction. start_i stays high unless an idle gap follows,
  // so back-to-back readings never lower and raise it in the same step.
  task automatic send_reading(input logic [15:0] id, input logic [15:0] rd);
    start_i     <= 1'b1;
    sensor_id_i <= id;
    reading_i   <= rd;
    do @(posedge clk_i); while (busy_o);
    if ($urandom_range(99) < idle_pct) begin
      start_i     <= 1'b0;
      sensor_id_i <= 16'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Limit writes only while the table is idle.
  task automatic write_limit(input logic [0:0] idx, input logic [15:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input int n, input logic signed [15:0] center);
    logic [15:0] id;
    logic [15:0] rd;
    for (int i = 0; i < n; i++) begin
      // mostly known sensors so windows fill and slide; some fresh ids
      id = ($urandom_range(99) < 88) ? known_ids[$urandom_range(15)] : 16'($urandom);
      case ($urandom_range(3))
        0: rd = 16'($urandom);
        1: rd = ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
        default: rd = 16'(int'(center) + int'($urandom_range(512)) - 256);
      endcase
      send_reading(id, rd);
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme ids and readings, fill the table, fill one window,
    // then a reading from an unknown sensor hits a full table.
    known_ids[0] = 16'h0000;
    known_ids[1] = 16'hffff;
    for (int k = 2; k < 16; k++) known_ids[k] = 16'h1000 + 16'(k * 16'h0111);
    send_reading(known_ids[0], 16'h8000);
    send_reading(known_ids[1], 16'h7fff);
    for (int k = 2; k < 16; k++) send_reading(known_ids[k], 16'(k * 16'h0900));
    for (int k = 0; k < 8; k++) send_reading(known_ids[0], 16'h8000);
    send_reading(16'h5a5a, 16'h0100);

    // Limits at the extremes: a full window far below the top reads as too cold.
    write_limit(krat_pkg::CFG_LOW_LIMIT, 16'h7fff);
    write_limit(krat_pkg::CFG_HIGH_LIMIT, 16'h8000);
    send_reading(known_ids[0], 16'h7fff);

    // Random phases across idle mixes and limit settings.
    for (int p = 0; p < 8; p++) begin
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 48;
        2: idle_pct = 0;
        default: idle_pct = 17;
      endcase
      case (p)
        0: begin lo = 16'sh8000; hi = 16'sh7fff; end
        1: begin lo = 16'sh0000; hi = 16'sh0000; end
        2: begin lo = 16'sh7fff; hi = 16'sh8000; end
        default: begin
          lo = 16'($urandom);
          hi = 16'(int'(lo) + int'($urandom_range(300)));
        end
      endcase
      write_limit(krat_pkg::CFG_LOW_LIMIT, lo);
      write_limit(krat_pkg::CFG_HIGH_LIMIT, hi);
      random_phase(160, lo);
      // hold off once until every result is back
      if (p == 4) drain();
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_keyed_running_average_table OK");
    end else begin
      $display("tb_keyed_running_average_table NOT OK");
    end
    $finish;
  end

endmodule
